[rtl/tss_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  // Width of the packed input data word: target, slot, flags, current slot,
  // padded to whole bytes.
  localparam int IN_DATA_W = 104;
  localparam int ADDR_W    = 64;
  localparam int SLOT_W    = 3;
  localparam int FLAGS_W   = 32;

  // Low flag bits that mark a slot as active.
  localparam logic [3:0] ACTIVE_MASK = 4'hF;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_SVC = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STAT_EMPTY    = 3'd0,
    STAT_JUMP     = 3'd1,
    STAT_UPDATED  = 3'd2,
    STAT_PICKED   = 3'd3,
    STAT_NONE     = 3'd4,
    STAT_ENQUEUED = 3'd5,
    STAT_DROPPED  = 3'd6
  } status_t;

  // A classified input item as it travels from the front end to the back end.
  // Slot numbers are already reduced to the slot table size.
  typedef struct packed {
    kind_t               kind;
    logic [ADDR_W-1:0]   target;
    logic [SLOT_W-1:0]   slot;
    logic                active;
    logic [SLOT_W-1:0]   cur;
  } item_t;

  // One entry of the command ring. Only the active bit of the flags matters.
  typedef struct packed {
    logic                active;
    logic [SLOT_W-1:0]   slot;
    logic [ADDR_W-1:0]   target;
  } qent_t;

endpackage

`default_nettype wire

[rtl/tss_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module tss_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/tss_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tss_front #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [tss_pkg::IN_DATA_W-1:0] s_tdata,
  input  wire logic                          s_tuser,
  output logic                               item_valid,
  output tss_pkg::item_t                     item,
  input  wire logic                          item_pop
);

  // Reduces a three-bit slot number modulo the table size.
  function automatic logic [tss_pkg::SLOT_W-1:0] slot_mod(
    input logic [tss_pkg::SLOT_W-1:0] v
  );
    int r;
    r = int'(v);
    for (int k = 0; k < 8; k++) begin
      if (r >= NUM_SLOTS) begin
        r = r - NUM_SLOTS;
      end
    end
    return tss_pkg::SLOT_W'(r);
  endfunction

  tss_pkg::item_t in_item;
  tss_pkg::item_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    in_item.kind   = tss_pkg::kind_t'(s_tuser);
    in_item.target = s_tdata[63:0];
    in_item.slot   = slot_mod(s_tdata[66:64]);
    in_item.active = |(s_tdata[70:67] & tss_pkg::ACTIVE_MASK);
    in_item.cur    = slot_mod(s_tdata[101:99]);
  end

  assign s_tready   = (count != 2'd2);
  assign push       = s_tvalid && s_tready;
  assign item_valid = (count != 2'd0);
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, item_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/tss_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module tss_back #(
  parameter int NUM_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       item_valid,
  input  wire tss_pkg::item_t             item,
  output logic                            item_pop,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [tss_pkg::ADDR_W-1:0]      jump_addr,
  output tss_pkg::status_t                status
);

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int QE = $bits(tss_pkg::qent_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_PICK
  } state_t;

  state_t                     state;
  logic [QW-1:0]              wr_idx;
  logic [QW-1:0]              rd_idx;
  logic [QW-1:0]              wr_next;
  logic [QW-1:0]              rd_next;
  logic                       full;
  logic                       empty;
  logic [NUM_SLOTS-1:0]       active;
  logic [SW-1:0]              cur;
  logic [SW-1:0]              cur_next;
  logic [SW-1:0]              scan_idx;
  logic [SW-1:0]              scan_next;
  logic [SW-1:0]              scan_cnt;

  tss_pkg::qent_t             wr_ent;
  logic [QE-1:0]              q_rd_data;
  tss_pkg::qent_t             pop_ent;
  logic [SW-1:0]              pop_slot;
  logic                       q_wr_en;
  logic                       q_rd_en;
  logic                       s_wr_en;
  logic                       s_rd_en;
  logic [tss_pkg::ADDR_W-1:0] s_rd_data;

  assign wr_next   = (wr_idx == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
  assign rd_next   = (rd_idx == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
  assign cur_next  = (cur == SW'(NUM_SLOTS - 1)) ? '0 : cur + 1'b1;
  assign scan_next = (scan_idx == SW'(NUM_SLOTS - 1)) ? '0 : scan_idx + 1'b1;
  assign full      = (wr_next == rd_idx);
  assign empty     = (wr_idx == rd_idx);

  assign item_pop = (state == S_IDLE) && item_valid && !m_tvalid;
  assign q_wr_en  = item_pop && (item.kind == tss_pkg::KIND_ENQ) && !full;
  assign q_rd_en  = item_pop && (item.kind == tss_pkg::KIND_SVC) && !empty;

  always_comb begin
    wr_ent.active = item.active;
    wr_ent.slot   = item.slot;
    wr_ent.target = item.target;
  end

  assign pop_ent  = q_rd_data;
  assign pop_slot = SW'(pop_ent.slot);
  assign s_wr_en  = (state == S_POP) && (pop_ent.target != '0);
  assign s_rd_en  = (state == S_SCAN) && active[scan_idx];

  tss_ram #(
    .WIDTH (QE),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (q_wr_en),
    .wr_addr (wr_idx),
    .wr_data (wr_ent),
    .rd_en   (q_rd_en),
    .rd_addr (rd_idx),
    .rd_data (q_rd_data)
  );

  tss_ram #(
    .WIDTH (tss_pkg::ADDR_W),
    .DEPTH (NUM_SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (s_wr_en),
    .wr_addr (pop_slot),
    .wr_data (pop_ent.target),
    .rd_en   (s_rd_en),
    .rd_addr (scan_idx),
    .rd_data (s_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wr_idx   <= '0;
      rd_idx   <= '0;
      active   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_pop) begin
            if (item.kind == tss_pkg::KIND_ENQ) begin
              m_tvalid  <= 1'b1;
              jump_addr <= '0;
              if (full) begin
                status <= tss_pkg::STAT_DROPPED;
              end else begin
                status <= tss_pkg::STAT_ENQUEUED;
                wr_idx <= wr_next;
              end
            end else if (empty) begin
              m_tvalid  <= 1'b1;
              jump_addr <= '0;
              status    <= tss_pkg::STAT_EMPTY;
            end else begin
              rd_idx <= rd_next;
              cur    <= SW'(item.cur);
              state  <= S_POP;
            end
          end
        end
        S_POP: begin
          if (pop_ent.target != '0) begin
            active[pop_slot] <= pop_ent.active;
            m_tvalid         <= 1'b1;
            if (pop_ent.active) begin
              jump_addr <= pop_ent.target;
              status    <= tss_pkg::STAT_JUMP;
            end else begin
              jump_addr <= '0;
              status    <= tss_pkg::STAT_UPDATED;
            end
            state <= S_IDLE;
          end else begin
            scan_idx <= cur_next;
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (active[scan_idx]) begin
            state <= S_PICK;
          end else if (scan_cnt == SW'(NUM_SLOTS - 2)) begin
            m_tvalid  <= 1'b1;
            jump_addr <= '0;
            status    <= tss_pkg::STAT_NONE;
            state     <= S_IDLE;
          end else begin
            scan_idx <= scan_next;
            scan_cnt <= scan_cnt + 1'b1;
          end
        end
        S_PICK: begin
          m_tvalid  <= 1'b1;
          jump_addr <= s_rd_data;
          status    <= tss_pkg::STAT_PICKED;
          state     <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/task_switch_scheduler.sv]
`timescale 1ns / 1ps
`default_nettype none

// Round-robin task switch scheduler with a command ring.
// Input beats arrive on the s_ channel. s_tuser selects the action: 0 queues
// a switch command (target, slot, flags), 1 services the oldest queued
// command. Every input beat yields exactly one result beat on the m_ channel:
// m_tdata carries the jump address (zero when there is no switch) and m_tuser
// carries the status code.
// A two-entry queue between the input classifier and the command engine lets
// the input side keep taking beats while a result waits on a stalled m_ side;
// when that queue fills, s_tready drops until the engine moves on.
// An enqueue or a service on an empty ring is answered directly when the engine
// takes the item; any other service first reads its command from the ring and
// answers if it carries a target. Otherwise the engine walks the active bits
// one slot per cycle from the slot after the current one, and a slot that it
// finds is then read from the slot table. The engine takes a new item only
// once it is idle and the previous result has left the m_ side.
// Reset clears the ring pointers, every slot's active bit and the output
// valid. Ring entries and slot targets are not cleared, since they are only
// read after they were written.

module task_switch_scheduler #(
  parameter int NUM_SLOTS   = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // s_tdata, from bit 0: target_addr[63:0], slot_index[66:64],
  // flag_word[98:67], current_slot[101:99], zero padding[103:102].
  input  wire logic [tss_pkg::IN_DATA_W-1:0] s_tdata,
  // s_tuser: action (0 enqueue, 1 service).
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // m_tdata: jump_addr[63:0].
  output logic [tss_pkg::ADDR_W-1:0]         m_tdata,
  // m_tuser: status[2:0].
  output logic [2:0]                         m_tuser
);

  logic             item_valid;
  logic             item_pop;
  tss_pkg::item_t   item;
  tss_pkg::status_t status;

  // Front end: decodes the beat, folds slot numbers into the table size,
  // reduces the flags to one active bit and buffers the classified item.
  tss_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  // Back end: owns the command ring, the slot table and the output register.
  tss_back #(
    .NUM_SLOTS   (NUM_SLOTS),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .jump_addr  (m_tdata),
    .status     (status)
  );

  assign m_tuser = status;

  // The engine only takes an item that the front end actually holds.
  assert property (@(posedge clk) disable iff (rst) item_pop |-> item_valid)
    else $error("engine popped an empty item queue");

  // The engine only starts an item once the previous result has left.
  assert property (@(posedge clk) disable iff (rst) item_pop |-> !m_tvalid)
    else $error("engine started while a result was pending");

  // Only a commanded jump or a round-robin pick carries an address.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != tss_pkg::STAT_JUMP) && (m_tuser != tss_pkg::STAT_PICKED)
      |-> (m_tdata == '0))
    else $error("nonzero jump address without a switch");

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_SLOTS   = 8;
  localparam int QUEUE_DEPTH = 16;

  // Run limits. The worst case adds the slowest legal beat, the longest sender
  // gap and a sparse receiver for every beat, plus the one long hold, so the
  // watchdog sits far above that sum.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 500;
  localparam int SEG_ITEMS     = 50;
  localparam int NUM_SEGS      = 18;
  localparam int MAX_MSG_LINES = 50;

  // One input beat before packing. Fields that the chosen action ignores
  // still carry random values so that every data bit toggles.
  typedef struct {
    tss_pkg::kind_t              kind;
    logic [tss_pkg::ADDR_W-1:0]  target;
    logic [tss_pkg::SLOT_W-1:0]  slot;
    logic [tss_pkg::FLAGS_W-1:0] flags;
    logic [tss_pkg::SLOT_W-1:0]  cur;
  } sched_cmd_t;

  // One result beat as the scheduler should produce it.
  typedef struct {
    logic [tss_pkg::ADDR_W-1:0] addr;
    tss_pkg::status_t           status;
  } sched_result_t;

  // Receiver ready styles; the style changes whenever rx_phase wraps.
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PERIODIC
  } rx_style_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tss_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tss_pkg::ADDR_W-1:0]    m_tdata;
  logic [2:0]                    m_tuser;

  // Beats waiting to be driven, and results owed by the scheduler in order.
  sched_cmd_t    pending_cmds[$];
  sched_result_t expected_results[$];

  // Shadow copy of the command ring and the task slot table.
  logic [tss_pkg::ADDR_W-1:0]  ring_target[QUEUE_DEPTH];
  int unsigned                 ring_slot[QUEUE_DEPTH];
  logic [tss_pkg::FLAGS_W-1:0] ring_flags[QUEUE_DEPTH];
  int unsigned                 ring_wr = 0;
  int unsigned                 ring_rd = 0;
  logic [tss_pkg::ADDR_W-1:0]  task_target[NUM_SLOTS] = '{default: '0};
  logic [tss_pkg::FLAGS_W-1:0] task_flags[NUM_SLOTS] = '{default: '0};

  int error_count  = 0;
  int result_count = 0;

  // Sender and receiver pacing state.
  sched_cmd_t  drive_cmd;
  int          burst_left;
  int          gap_left;
  rx_style_t   rx_style;
  int          rx_phase;
  int          hold_left;
  logic        hold_done;
  logic        long_hold_req = 1'b0;

  task_switch_scheduler #(
    .NUM_SLOTS  (NUM_SLOTS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Advances the shadow scheduler by one accepted beat and returns the result
  // it must produce. An enqueue fills the ring unless only one free entry is
  // left, which the ring keeps empty to tell full from empty. A service pops
  // one command: with a target it rewrites the slot and jumps if the slot is
  // now active, without one it walks the slots after the current one and
  // takes the first active slot, never the current slot itself.
  function automatic sched_result_t predict_switch(sched_cmd_t c);
    sched_result_t               r;
    int unsigned                 nxt;
    int unsigned                 sel;
    int unsigned                 idx;
    int                          n;
    logic [tss_pkg::ADDR_W-1:0]  tgt;
    logic [tss_pkg::FLAGS_W-1:0] flg;
    r.addr = '0;
    r.status = tss_pkg::STAT_NONE;
    if (c.kind == tss_pkg::KIND_ENQ) begin
      nxt = (ring_wr + 1) % QUEUE_DEPTH;
      if (nxt == ring_rd) begin
        r.status = tss_pkg::STAT_DROPPED;
      end else begin
        ring_target[ring_wr] = c.target;
        ring_slot[ring_wr] = c.slot % NUM_SLOTS;
        ring_flags[ring_wr] = c.flags;
        ring_wr = nxt;
        r.status = tss_pkg::STAT_ENQUEUED;
      end
    end else if (ring_wr == ring_rd) begin
      r.status = tss_pkg::STAT_EMPTY;
    end else begin
      tgt = ring_target[ring_rd];
      sel = ring_slot[ring_rd];
      flg = ring_flags[ring_rd];
      ring_rd = (ring_rd + 1) % QUEUE_DEPTH;
      if (tgt != '0) begin
        task_target[sel] = tgt;
        task_flags[sel] = flg;
        if ((flg[3:0] & tss_pkg::ACTIVE_MASK) != '0) begin
          r.addr = tgt;
          r.status = tss_pkg::STAT_JUMP;
        end else begin
          r.status = tss_pkg::STAT_UPDATED;
        end
      end else begin
        idx = ((c.cur % NUM_SLOTS) + 1) % NUM_SLOTS;
        for (n = 0; n < NUM_SLOTS - 1; n++) begin
          if (r.status == tss_pkg::STAT_NONE &&
              (task_flags[idx][3:0] & tss_pkg::ACTIVE_MASK) != '0) begin
            r.addr = task_target[idx];
            r.status = tss_pkg::STAT_PICKED;
          end
          idx = (idx + 1) % NUM_SLOTS;
        end
      end
    end
    return r;
  endfunction

  // Builds a random beat. The enqueue share steers the ring between empty
  // and full. Targets lean toward zero and toward the extremes, and a good
  // part of the flag words leave the slot inactive or set one active bit.
  function automatic sched_cmd_t random_cmd(int unsigned enq_pct);
    sched_cmd_t c;
    c.kind = ($urandom_range(99) < enq_pct) ? tss_pkg::KIND_ENQ : tss_pkg::KIND_SVC;
    case ($urandom_range(7))
      0, 1:    c.target = '0;
      2:       c.target = '1;
      3:       c.target = 64'd1 << $urandom_range(63);
      default: c.target = {$urandom, $urandom};
    endcase
    c.slot = tss_pkg::SLOT_W'($urandom_range(7));
    c.flags = $urandom;
    case ($urandom_range(5))
      0, 1:    c.flags[3:0] = '0;
      2:       c.flags[3:0] = 4'b0001 << $urandom_range(3);
      default: ;
    endcase
    c.cur = tss_pkg::SLOT_W'($urandom_range(7));
    return c;
  endfunction

  task automatic push_enq(logic [tss_pkg::ADDR_W-1:0] target,
                          logic [tss_pkg::SLOT_W-1:0] slot,
                          logic [tss_pkg::FLAGS_W-1:0] flags);
    sched_cmd_t c;
    c = random_cmd(0);
    c.kind = tss_pkg::KIND_ENQ;
    c.target = target;
    c.slot = slot;
    c.flags = flags;
    pending_cmds.push_back(c);
  endtask

  task automatic push_svc(logic [tss_pkg::SLOT_W-1:0] cur);
    sched_cmd_t c;
    c = random_cmd(0);
    c.kind = tss_pkg::KIND_SVC;
    c.cur = cur;
    pending_cmds.push_back(c);
  endtask

  task automatic push_segment(int unsigned enq_pct);
    int k;
    for (k = 0; k < SEG_ITEMS; k++) begin
      pending_cmds.push_back(random_cmd(enq_pct));
    end
  endtask

  // The sender holds off until nothing is queued, in flight or owed.
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Console output is capped so that a badly broken design cannot flood the
  // log; every mismatch still counts toward the verdict.
  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= MAX_MSG_LINES) begin
      $display("[%0t] mismatch on result beat %0d: %s", $realtime, result_count, msg);
    end
  endtask

  // Sender. It loads a new beat whenever the slot on the bus is free or was
  // just taken, and works in bursts of random length separated by random
  // gaps. A quarter of the gaps are zero, so back-to-back runs happen too.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0 || pending_cmds.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end
      end else begin
        drive_cmd = pending_cmds.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= drive_cmd.kind;
        s_tdata <= tss_pkg::IN_DATA_W'({drive_cmd.cur, drive_cmd.flags, drive_cmd.slot,
                                        drive_cmd.target});
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver. Ready follows one of four styles chosen as rx_phase wraps. Once,
  // on request, it holds ready low for a long stretch so that the output
  // stage and the internal queue fill up and the input side has to stall.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_style <= RX_OPEN;
      rx_phase <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      rx_phase <= (rx_phase == 63) ? 0 : rx_phase + 1;
      if (rx_phase == 63) begin
        rx_style <= rx_style_t'($urandom_range(3));
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else if (long_hold_req && !hold_done) begin
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
        m_tready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   m_tready <= 1'b1;
          RX_COIN:   m_tready <= 1'($urandom_range(1));
          RX_SPARSE: m_tready <= ($urandom_range(3) == 0);
          default:   m_tready <= (rx_phase % 7) >= 3;
        endcase
      end
    end
  end

  // Monitor. Results are checked against the oldest expectation before the input
  // beat of the same edge is predicted; a result never belongs to a beat taken at
  // that edge, since the front-end buffer and the output register lie between.
  always @(posedge clk) begin
    sched_cmd_t    seen;
    sched_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat addr %h status %0d", m_tdata, m_tuser));
        end else begin
          want = expected_results.pop_front();
          if (m_tdata !== want.addr) begin
            report_mismatch($sformatf("jump_addr %h, expected %h (%s)", m_tdata, want.addr,
                                      want.status.name()));
          end
          if (m_tuser !== want.status) begin
            report_mismatch($sformatf("status %0d, expected %0d (%s)", m_tuser, want.status,
                                      want.status.name()));
          end
        end
        result_count++;
      end
      if (s_tvalid && s_tready) begin
        seen.kind = tss_pkg::kind_t'(s_tuser);
        seen.target = s_tdata[63:0];
        seen.slot = s_tdata[66:64];
        seen.flags = s_tdata[98:67];
        seen.cur = s_tdata[101:99];
        expected_results.push_back(predict_switch(seen));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
      @(posedge clk);
    end
    $display("task_switch_scheduler test failed");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    int unsigned enq_mix[6];
    int          seg;
    enq_mix = '{50, 90, 15, 65, 35, 95};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. A service on the empty ring comes first. Then the
    // ring is filled to its last usable entry with commands that cover the
    // address and flag extremes, a pick with no slot active, picks that wrap
    // past the last slot, a slot that is rewritten to inactive, and a pick
    // where only the current slot is active. One more command is dropped
    // because the ring is full, and eight services pop the first commands.
    push_svc(3'd7);
    push_enq('0, 3'd3, $urandom);
    push_enq('1, 3'd7, '1);
    push_enq(64'd1, 3'd0, 32'h0000_0001);
    push_enq('0, 3'd5, $urandom);
    push_enq('0, 3'd2, $urandom);
    push_enq(64'h8000_0000_0000_0000, 3'd7, 32'hFFFF_FFF0);
    push_enq('0, 3'd6, $urandom);
    push_enq(64'hA5A5_5A5A_C3C3_3C3C, 3'd4, '0);
    push_enq(64'h5A5A_A5A5_3C3C_C3C3, 3'd1, 32'h0000_0008);
    repeat (6) pending_cmds.push_back(random_cmd(100));
    push_enq('1, 3'd2, '1);
    push_svc(3'd5);
    push_svc(3'd3);
    push_svc(3'd1);
    push_svc(3'd7);
    push_svc(3'd0);
    push_svc(3'd4);
    push_svc(3'd0);
    push_svc(3'd6);
    wait_drained();

    // First random half. The long receiver hold starts while most of it is
    // still queued, so the sender keeps offering beats into a stalled block.
    for (seg = 0; seg < NUM_SEGS / 2; seg++) begin
      push_segment(enq_mix[seg % 6]);
    end
    @(posedge clk);
    long_hold_req <= 1'b1;
    wait_drained();

    for (seg = NUM_SEGS / 2; seg < NUM_SEGS; seg++) begin
      push_segment(enq_mix[seg % 6]);
    end
    wait_drained();

    // Allow for the longest slot walk so that a stray extra beat is caught.
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("task_switch_scheduler test passed");
    end else begin
      $display("task_switch_scheduler test failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/tss_pkg.sv
rtl/tss_ram.sv
rtl/tss_front.sv
rtl/tss_back.sv
rtl/task_switch_scheduler.sv
dv/tb_top.sv
